// File: hw/rtl/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg: shared types and constants for the bearing alignment check
// Holds field widths, the CORDIC angle table and the item struct that moves
// from the front part to the back part.
// ----------------------------------------------------------------------------
package bac_pkg;

    localparam int CoordW    = 16;
    localparam int AngW      = 17;
    localparam int DistW     = 17;
    localparam int AlignW    = 16;
    localparam int Stages    = 16;
    localparam int ScaleSh   = 44 - CoordW;
    // CORDIC datapath: dx scaled by 2^28 fits 46 bits, growth below 2 more
    localparam int CW        = 48;
    localparam int ZW        = 34;
    localparam int SqW       = 36;              // dx^2 + dy^2 of 17-bit values
    localparam int RootSteps = SqW / 2;

    localparam int FifoDepth = 4;
    localparam int FifoAw    = 2;

    localparam int CfgAw = 1;
    localparam logic [CfgAw-1:0] CFG_ZERO_TOL  = 1'b0;
    localparam logic [CfgAw-1:0] CFG_ALIGN_TOL = 1'b1;

    typedef struct packed {
        logic signed [CoordW:0]  dx;
        logic signed [CoordW:0]  dy;
        logic signed [AngW-1:0]  heading;
    } t_item;

    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] v;
        v = '0;
        case (i)
            0:  v = 34'sd536870912;
            1:  v = 34'sd316933406;
            2:  v = 34'sd167458907;
            3:  v = 34'sd85004756;
            4:  v = 34'sd42667331;
            5:  v = 34'sd21354465;
            6:  v = 34'sd10680094;
            7:  v = 34'sd5340245;
            8:  v = 34'sd2670163;
            9:  v = 34'sd1335087;
            10: v = 34'sd667544;
            11: v = 34'sd333772;
            12: v = 34'sd166886;
            13: v = 34'sd83443;
            14: v = 34'sd41722;
            15: v = 34'sd20861;
            16: v = 34'sd10430;
            17: v = 34'sd5215;
            18: v = 34'sd2608;
            19: v = 34'sd1304;
            20: v = 34'sd652;
            21: v = 34'sd326;
            22: v = 34'sd163;
            23: v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/bac_front.sv
// ----------------------------------------------------------------------------
// bac_front: input stage
// Registers the point pair and forms the coordinate differences.
// ----------------------------------------------------------------------------
module bac_front import bac_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [CoordW-1:0] i_origin_x,
    input  logic signed [CoordW-1:0] i_origin_y,
    input  logic signed [AngW-1:0]   i_heading,
    input  logic signed [CoordW-1:0] i_target_x,
    input  logic signed [CoordW-1:0] i_target_y,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_item                    o_item
);

    logic  r_valid;
    t_item r_item;
    logic  w_take;

    assign o_full  = r_valid && !i_ready;
    assign w_take  = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.dx      <= {i_target_x[CoordW-1], i_target_x}
                            - {i_origin_x[CoordW-1], i_origin_x};
            r_item.dy      <= {i_target_y[CoordW-1], i_target_y}
                            - {i_origin_y[CoordW-1], i_origin_y};
            r_item.heading <= i_heading;
        end
    end

endmodule

// File: hw/rtl/bac_fifo.sv
// ----------------------------------------------------------------------------
// bac_fifo: short queue between the front and back parts
// Register-based FIFO with first-word-fall-through output.
// ----------------------------------------------------------------------------
module bac_fifo import bac_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    output logic  o_ready,
    input  t_item i_data,
    output logic  o_valid,
    input  logic  i_rd,
    output t_item o_data
);

    t_item             r_mem [FifoDepth];
    logic [FifoAw-1:0] r_wp, r_rp;
    logic [FifoAw:0]   r_cnt;
    logic              w_wr, w_rd;

    assign o_ready = r_cnt != FifoAw'(0) + (FifoAw+1)'(FifoDepth);
    assign o_valid = r_cnt != '0;
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_rd && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FifoAw+1)'(FifoDepth))
        else $error("fifo count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("fifo count did not grow on write");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("empty fifo pointers differ");

endmodule

// File: hw/rtl/bac_back.sv
// ----------------------------------------------------------------------------
// bac_back: CORDIC and square root pipeline with output queue
// One root step per pipeline stage after stage 0, one CORDIC stage in the first
// Stages; all advance together, stalling only when the last stage cannot drain.
// ----------------------------------------------------------------------------
module bac_back import bac_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_item                   i_item,
    input  logic [DistW-1:0]        i_zero_tol,
    input  logic [AlignW-1:0]       i_align_tol,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic [DistW-1:0]        o_distance,
    output logic signed [AngW-1:0]  o_bearing_error,
    output logic                    o_target_distinct,
    output logic                    o_aligned
);

    localparam int NS = (Stages > RootSteps) ? Stages : RootSteps;

    // pipeline stage registers; stage 0 is the pre-rotation
    logic                    r_v   [NS+1];
    logic signed [CW-1:0]    r_x   [NS+1];
    logic signed [CW-1:0]    r_y   [NS+1];
    logic signed [ZW-1:0]    r_z   [NS+1];
    logic signed [AngW-1:0]  r_hd  [NS+1];
    logic                    r_nz  [NS+1];
    logic [SqW-1:0]          r_rem [NS+1];
    logic [SqW-1:0]          r_rt  [NS+1];

    logic w_adv;
    // output queue
    logic [DistW-1:0]       r_od  [FifoDepth];
    logic signed [AngW-1:0] r_oe  [FifoDepth];
    logic                   r_ot  [FifoDepth];
    logic                   r_oa  [FifoDepth];
    logic [FifoAw-1:0]      r_wp, r_rp;
    logic [FifoAw:0]        r_cnt;
    logic                   w_full_q, w_wr, w_rd;

    // hold the whole pipeline only while a finished item waits on a full queue
    assign w_full_q = r_cnt == (FifoAw+1)'(FifoDepth);
    assign w_adv    = !(r_v[NS] && w_full_q) || w_rd;
    assign o_ready  = w_adv;

    // stage 0: quadrant fold and squared magnitude
    logic signed [CW-1:0]   w_x0, w_y0, w_xs, w_ys;
    logic signed [ZW-1:0]   w_z0;
    logic [CoordW:0]        w_adx, w_ady;
    logic [2*CoordW+1:0]    w_sqx, w_sqy;
    always_comb begin
        w_xs = CW'(i_item.dx) <<< ScaleSh;
        w_ys = CW'(i_item.dy) <<< ScaleSh;
        w_x0 = w_xs;
        w_y0 = w_ys;
        w_z0 = '0;
        if (w_xs < 0) begin
            if (w_ys >= 0) begin
                w_x0 = w_ys;  w_y0 = -w_xs; w_z0 = ZW'(34'sd1 <<< 30);
            end else begin
                w_x0 = -w_ys; w_y0 = w_xs;  w_z0 = -ZW'(34'sd1 <<< 30);
            end
        end
        w_adx = i_item.dx[CoordW] ? (CoordW+1)'(0) - i_item.dx : i_item.dx;
        w_ady = i_item.dy[CoordW] ? (CoordW+1)'(0) - i_item.dy : i_item.dy;
        w_sqx = w_adx * w_adx;
        w_sqy = w_ady * w_ady;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_x[0]   <= w_x0;
            r_y[0]   <= w_y0;
            r_z[0]   <= w_z0;
            r_hd[0]  <= i_item.heading;
            r_nz[0]  <= (i_item.dx != '0) || (i_item.dy != '0);
            r_rem[0] <= SqW'(w_sqx) + SqW'(w_sqy);
            r_rt[0]  <= '0;
        end
    end

    // stages 1..NS: one root bit each, and one CORDIC step in the first Stages
    for (genvar s = 0; s < NS; s++) begin : g_st
        logic signed [CW-1:0] w_xn, w_yn;
        logic signed [ZW-1:0] w_zn;
        logic [SqW-1:0]       w_rn, w_tn, w_bit;
        always_comb begin
            w_xn = r_x[s];
            w_yn = r_y[s];
            w_zn = r_z[s];
            if (s < Stages) begin
                if (r_y[s] >= 0) begin
                    w_xn = r_x[s] + (r_y[s] >>> s);
                    w_yn = r_y[s] - (r_x[s] >>> s);
                    w_zn = r_z[s] + atan_tab(s);
                end else begin
                    w_xn = r_x[s] - (r_y[s] >>> s);
                    w_yn = r_y[s] + (r_x[s] >>> s);
                    w_zn = r_z[s] - atan_tab(s);
                end
            end
            w_rn  = r_rem[s];
            w_tn  = r_rt[s];
            w_bit = SqW'(1) << (SqW - 2 - 2 * s);
            if (s < RootSteps) begin
                if (r_rem[s] >= r_rt[s] + w_bit) begin
                    w_rn = r_rem[s] - (r_rt[s] + w_bit);
                    w_tn = (r_rt[s] >> 1) + w_bit;
                end else begin
                    w_tn = r_rt[s] >> 1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (w_adv) begin
                r_v[s+1] <= r_v[s];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_x[s+1]   <= w_xn;
                r_y[s+1]   <= w_yn;
                r_z[s+1]   <= w_zn;
                r_hd[s+1]  <= r_hd[s];
                r_nz[s+1]  <= r_nz[s];
                r_rem[s+1] <= w_rn;
                r_rt[s+1]  <= w_tn;
            end
        end
    end

    // final stage: rounding, wrap, compare
    logic signed [ZW-1:0]  w_zr;
    logic [15:0]           w_b16, w_e16;
    logic signed [AngW-1:0] w_b, w_err, w_e;
    logic [DistW-1:0]      w_dist;
    logic                  w_dis, w_al;
    logic [AngW-1:0]       w_mag;
    always_comb begin
        w_zr   = r_z[NS] + ZW'(32768);
        w_b16  = w_zr[31:16];
        w_b    = r_nz[NS] ? {1'b0, w_b16} : '0;
        w_err  = w_b - r_hd[NS];
        w_e16  = w_err[15:0];
        w_e    = (w_e16 > 16'd32768 ) ? AngW'(w_e16) - AngW'(65536) : AngW'(w_e16);
        if (w_e16 == 16'd32768) w_e = AngW'(32768);
        w_dist = r_rt[NS][DistW-1:0];
        w_dis  = w_dist > i_zero_tol;
        w_mag  = w_e[AngW-1] ? AngW'(0) - w_e : w_e;
        w_al   = w_dis && (w_mag < {1'b0, i_align_tol});
    end

    assign w_wr = r_v[NS] && w_adv;
    assign w_rd = i_pop && (r_cnt != '0);
    assign o_empty = r_cnt == '0;
    assign o_distance        = r_od[r_rp];
    assign o_bearing_error   = r_oe[r_rp];
    assign o_target_distinct = r_ot[r_rp];
    assign o_aligned         = r_oa[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_od[r_wp] <= w_dist;
            r_oe[r_wp] <= w_dis ? w_e : '0;
            r_ot[r_wp] <= w_dis;
            r_oa[r_wp] <= w_al;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            if (w_wr && !w_rd) r_cnt <= r_cnt + 1'b1;
            else if (w_rd && !w_wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FifoAw+1)'(FifoDepth))
        else $error("result queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |-> (r_cnt != (FifoAw+1)'(FifoDepth)) || w_rd)
        else $error("write into full result queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NS] && w_full_q && !w_rd) |-> !w_adv)
        else $error("pipeline advanced into full result queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |-> w_full_q)
        else $error("pipeline stalled with room in result queue");

endmodule

// File: hw/rtl/bearing_alignment_check_core.sv
// ----------------------------------------------------------------------------
// bearing_alignment_check_core: bearing error and alignment test
// Distance and CORDIC atan2 from origin to target, error against heading.
//
//  channel | handshake         | payload
//  input   | push / full       | origin_x/y, heading, target_x/y
//  result  | empty / pop       | distance, bearing_error, target_distinct, aligned
//  config  | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while not stalled; items pass through the 18-step
// root / 16-stage CORDIC pipeline. Synchronous active-low reset clears all
// control. The pipeline stalls only when the 4-entry result queue is full.
// ----------------------------------------------------------------------------
module bearing_alignment_check_core import bac_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [CoordW-1:0] i_origin_x,
    input  logic signed [CoordW-1:0] i_origin_y,
    input  logic signed [AngW-1:0]   i_heading,
    input  logic signed [CoordW-1:0] i_target_x,
    input  logic signed [CoordW-1:0] i_target_y,
    output logic                    empty,
    input  logic                    pop,
    output logic [DistW-1:0]        o_distance,
    output logic signed [AngW-1:0]  o_bearing_error,
    output logic                    o_target_distinct,
    output logic                    o_aligned,
    input  logic                    i_cfg_we,
    input  logic [CfgAw-1:0]        i_cfg_idx,
    input  logic [DistW-1:0]        i_cfg_data
);

    logic [DistW-1:0]  r_zero_tol;
    logic [AlignW-1:0] r_align_tol;
    logic  w_fv, w_fr, w_qv, w_qr;
    t_item w_fi, w_qi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol  <= DistW'(1);
            r_align_tol <= AlignW'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ZERO_TOL:  r_zero_tol  <= i_cfg_data;
                CFG_ALIGN_TOL: r_align_tol <= i_cfg_data[AlignW-1:0];
                default: ;
            endcase
        end
    end

    bac_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_origin_x, .i_origin_y, .i_heading, .i_target_x, .i_target_y,
        .o_valid(w_fv), .i_ready(w_fr), .o_item(w_fi)
    );

    bac_fifo u_fifo (
        .i_clk, .i_rst_n, .i_wr(w_fv), .o_ready(w_fr), .i_data(w_fi),
        .o_valid(w_qv), .i_rd(w_qr), .o_data(w_qi)
    );

    bac_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_qi),
        .i_zero_tol(r_zero_tol), .i_align_tol(r_align_tol),
        .o_empty(empty), .i_pop(pop),
        .o_distance, .o_bearing_error, .o_target_distinct, .o_aligned
    );

endmodule
